// File: rtl/rgbbp_pkg.sv
// Shared types, constants and pixel unpacking functions for the bitplane packer.
package rgbbp_pkg;

  localparam int COLOR_DEPTH = 8;
  localparam int PLANE_W     = 3;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 6;
  localparam int SLOT_W      = 3;
  localparam int GAMMA_DEPTH = 256;
  localparam int ADDR_W      = 15;
  localparam int POS_W       = 12;
  localparam int STRIDE_W    = 13;
  localparam int PIX_W       = 24;
  localparam int BITS_W      = 6;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd2048;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_RGB888 = 2'd1;
  localparam logic [1:0] MODE_RGB565 = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [PIX_W-1:0] top_pixel;
    logic [PIX_W-1:0] bottom_pixel;
    logic [POS_W-1:0] out_position;
    logic [CH_W-1:0]  lut_index;
    logic [CH_W-1:0]  lut_value;
  } in_item_t;

  typedef struct packed {
    logic [PLANE_W-1:0] plane_index;
    logic [ADDR_W-1:0]  output_address;
    logic [BITS_W-1:0]  packed_bits;
    logic               last;
  } out_item_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] chan_vec_t;
  typedef logic [2:0][CH_W-1:0]        rgb_t;

  typedef struct packed {
    chan_vec_t        gamma;
    logic [POS_W-1:0] position;
  } pair_t;

  // Channel 0 is red, 1 green, 2 blue. The low byte of the word comes first.
  function automatic rgb_t widen565(logic [15:0] word);
    rgb_t       ch;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [5:0] g6;
    lo = word[7:0];
    hi = word[15:8];
    g6 = {hi[2:0], lo[7:5]};
    ch[0] = {hi[7:3], hi[7:5]};
    ch[1] = {g6, g6[5:4]};
    ch[2] = {lo[4:0], lo[4:2]};
    return ch;
  endfunction

  function automatic rgb_t split888(logic [PIX_W-1:0] pix);
    rgb_t ch;
    ch[0] = pix[7:0];
    ch[1] = pix[15:8];
    ch[2] = pix[23:16];
    return ch;
  endfunction

  // Gamma table addresses of the six channels: top R,G,B then bottom R,G,B.
  function automatic chan_vec_t channel_addrs(logic [1:0] mode, logic [PIX_W-1:0] top,
                                              logic [PIX_W-1:0] bottom);
    chan_vec_t addrs;
    rgb_t      t;
    rgb_t      b;
    if (mode == MODE_RGB565) begin
      t = widen565(top[15:0]);
      b = widen565(bottom[15:0]);
    end else begin
      t = split888(top);
      b = split888(bottom);
    end
    addrs = {b, t};
    return addrs;
  endfunction

endpackage

// File: rtl/rgbbp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rgbbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rgbbp_lookup.sv
// Gamma table and the read sequencer that looks up the six channels of a pixel pair.
module rgbbp_lookup (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  rgbbp_pkg::in_item_t item,
  output logic                item_take,
  output logic                pair_valid,
  output rgbbp_pkg::pair_t    pair_data,
  input  logic                pair_take
);

  localparam logic [rgbbp_pkg::SLOT_W-1:0] LAST_SLOT = rgbbp_pkg::SLOT_W'(rgbbp_pkg::NUM_CH - 1);

  logic                                busy_r, busy_nxt;
  logic [rgbbp_pkg::SLOT_W-1:0]        cnt_r, cnt_nxt;
  logic                                pend_r, pend_nxt;
  logic [rgbbp_pkg::SLOT_W-1:0]        slot_r;
  logic                                done_r, done_nxt;
  rgbbp_pkg::chan_vec_t                addr_r;
  rgbbp_pkg::chan_vec_t                ch_r;
  logic [rgbbp_pkg::POS_W-1:0]         pos_r;
  logic                                ready;
  logic                                take;
  logic                                start;
  logic                                we;
  logic [rgbbp_pkg::CH_W-1:0]          raddr;
  logic [rgbbp_pkg::CH_W-1:0]          rdata;

  // A new item only starts once the previous one has left the gather registers.
  assign ready     = !busy_r && !pend_r && (!done_r || pair_take);
  assign take      = item_valid && ready;
  assign item_take = take;
  assign we        = take && (item.mode == rgbbp_pkg::MODE_LOAD);
  assign start     = take && (item.mode inside {rgbbp_pkg::MODE_RGB888,
                                                rgbbp_pkg::MODE_RGB565});
  assign raddr     = addr_r[cnt_r];

  rgbbp_ram #(
    .WIDTH (rgbbp_pkg::CH_W),
    .DEPTH (rgbbp_pkg::GAMMA_DEPTH)
  ) u_gamma_ram (
    .clk   (clk),
    .we    (we),
    .waddr (item.lut_index),
    .wdata (item.lut_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_SLOT) begin
        busy_nxt = 1'b0;
      end
    end
    pend_nxt = busy_r;
    if (pend_r && slot_r == LAST_SLOT) begin
      done_nxt = 1'b1;
    end else if (pair_take) begin
      done_nxt = 1'b0;
    end else begin
      done_nxt = done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
      slot_r <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      slot_r <= cnt_r;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= rgbbp_pkg::channel_addrs(item.mode, item.top_pixel, item.bottom_pixel);
      pos_r  <= item.out_position;
    end
    if (pend_r) begin
      ch_r[slot_r] <= rdata;
    end
  end

  assign pair_valid         = done_r;
  assign pair_data.gamma    = ch_r;
  assign pair_data.position = pos_r;

endmodule

// File: rtl/rgb_pair_to_bitplanes.sv
// Top level: input buffer, gamma lookup and the bitplane beat emitter.
// An accepted pixel pair passes the input buffer, lookup sequencer, gamma RAM read, gather
// registers and emitter register. The pair rate is set by the six reads through the single
// read port of the gamma RAM plus gathering, matched by the eight result beats of the emitter.
// A gamma load or an unused mode is taken by the lookup sequencer and yields no beat.
// Synchronous active-low reset clears the handshake state and sets the stride to 2048.
module rgb_pair_to_bitplanes (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rgbbp_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rgbbp_pkg::out_item_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgbbp_pkg::STRIDE_W-1:0]      cfg_data
);

  localparam logic [rgbbp_pkg::PLANE_W-1:0] LAST_PLANE =
    rgbbp_pkg::PLANE_W'(rgbbp_pkg::COLOR_DEPTH - 1);

  logic                               in_full_r;
  rgbbp_pkg::in_item_t                in_item_r;
  logic                               in_accept;
  logic                               item_take;
  logic [rgbbp_pkg::STRIDE_W-1:0]     stride_r;
  logic                               pair_valid;
  rgbbp_pkg::pair_t                   pair_data;
  logic                               pair_take;
  logic                               emit_active_r, emit_active_nxt;
  logic [rgbbp_pkg::PLANE_W-1:0]      plane_r;
  rgbbp_pkg::chan_vec_t               gamma_r;
  logic [rgbbp_pkg::ADDR_W-1:0]       addr_r;
  logic                               out_valid_r, out_valid_nxt;
  rgbbp_pkg::out_item_t               out_data_r;
  logic                               load_out;
  logic                               last_plane;
  logic [rgbbp_pkg::BITS_W-1:0]       bits;

  assign in_stall  = in_full_r && !item_take;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      stride_r  <= rgbbp_pkg::STRIDE_RESET;
    end else begin
      in_full_r <= in_accept || (in_full_r && !item_take);
      if (cfg_valid) begin
        stride_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_data;
    end
  end

  rgbbp_lookup u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_full_r),
    .item       (in_item_r),
    .item_take  (item_take),
    .pair_valid (pair_valid),
    .pair_data  (pair_data),
    .pair_take  (pair_take)
  );

  // The emitter steps through the planes, adding the stride once per beat.
  assign load_out   = emit_active_r && (!out_valid_r || !out_stall);
  assign last_plane = (plane_r == LAST_PLANE);
  assign pair_take  = pair_valid && (!emit_active_r || (load_out && last_plane));

  always_comb begin
    if (pair_take) begin
      emit_active_nxt = 1'b1;
    end else if (load_out && last_plane) begin
      emit_active_nxt = 1'b0;
    end else begin
      emit_active_nxt = emit_active_r;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    for (int i = 0; i < rgbbp_pkg::NUM_CH; i++) begin
      bits[i] = gamma_r[i][plane_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
      plane_r       <= '0;
    end else begin
      emit_active_r <= emit_active_nxt;
      out_valid_r   <= out_valid_nxt;
      if (pair_take) begin
        plane_r <= '0;
      end else if (load_out) begin
        plane_r <= plane_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_take) begin
      gamma_r <= pair_data.gamma;
      addr_r  <= rgbbp_pkg::ADDR_W'(pair_data.position);
    end else if (load_out) begin
      addr_r <= addr_r + rgbbp_pkg::ADDR_W'(stride_r);
    end
    if (load_out) begin
      out_data_r.plane_index    <= plane_r;
      out_data_r.output_address <= addr_r;
      out_data_r.packed_bits    <= bits;
      out_data_r.last           <= last_plane;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/rgbbp_checker.sv
// Port-level checks on the result channel of the bitplane packer, bound to the top level.
module rgbbp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input rgbbp_pkg::out_item_t out_data
);

  localparam logic [rgbbp_pkg::PLANE_W-1:0] LAST_PLANE =
    rgbbp_pkg::PLANE_W'(rgbbp_pkg::COLOR_DEPTH - 1);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_plane_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.plane_index == $past(out_data.plane_index) + 1'b1)
    else $error("bitplane beats of a pair not contiguous");

  a_last_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.plane_index == LAST_PLANE)))
    else $error("last flag disagrees with plane index");

  a_pair_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid || out_data.plane_index == '0)
    else $error("new pair does not start at plane zero");

endmodule

bind rgb_pair_to_bitplanes rgbbp_checker u_rgbbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
